FILE: sv/trf_pkg.sv
package trf_pkg;

  localparam int AXIS_W = 12;
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(AXIS_W - 1);

  localparam logic [15:0] REPEAT_MAX = 16'hFFFF;
  localparam logic [3:0]  NIBBLE_MASK = 4'hF;

  // result status codes
  localparam logic [2:0] ST_FRESH    = 3'd0;
  localparam logic [2:0] ST_BUS_ERR  = 3'd1;
  localparam logic [2:0] ST_RELEASE  = 3'd2;
  localparam logic [2:0] ST_STUCK    = 3'd3;
  localparam logic [2:0] ST_STUCK_NEW = 3'd4;
  localparam logic [2:0] ST_HELD     = 3'd5;
  localparam logic [2:0] ST_REJECTED = 3'd6;

  // configuration register indexes
  localparam logic [2:0] REG_X_CAL_MIN    = 3'd0;
  localparam logic [2:0] REG_X_CAL_MAX    = 3'd1;
  localparam logic [2:0] REG_Y_CAL_MIN    = 3'd2;
  localparam logic [2:0] REG_Y_CAL_MAX    = 3'd3;
  localparam logic [2:0] REG_X_SCALED_MAX = 3'd4;
  localparam logic [2:0] REG_Y_SCALED_MAX = 3'd5;
  localparam logic [2:0] REG_RESCALE      = 3'd6;
  localparam logic [2:0] REG_ROTATION     = 3'd7;

  // quarter turns
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  typedef struct packed {
    logic       bus_ok;
    logic [7:0] x_high_byte;
    logic [7:0] x_low_byte;
    logic [7:0] y_high_byte;
    logic [7:0] y_low_byte;
  } in_word_t;

  typedef struct packed {
    logic              pressed;
    logic [AXIS_W-1:0] point_x;
    logic [AXIS_W-1:0] point_y;
    logic              reset_bus;
    logic [2:0]        status;
  } out_word_t;

  typedef struct packed {
    logic [AXIS_W-1:0] value;
    logic [AXIS_W-1:0] lo;
    logic [AXIS_W-1:0] hi;
    logic [AXIS_W-1:0] top;
  } scale_req_t;

endpackage

FILE: sv/trf_scale.sv
module trf_scale (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  trf_pkg::scale_req_t req,
  output logic               busy,
  output logic [trf_pkg::AXIS_W-1:0] quo
);
  import trf_pkg::*;

  // one bit a cycle: shift-add multiply, then restoring divide in place
  logic              div_phase;
  logic [STEP_W-1:0] count;
  logic [AXIS_W-1:0] mul_sh;
  logic [AXIS_W-1:0] diff;
  logic [AXIS_W-1:0] span;
  logic [2*AXIS_W-1:0] prod;

  logic [AXIS_W:0]   trial;
  logic [AXIS_W:0]   trial_sub;
  logic [2*AXIS_W-1:0] mul_next;
  logic [2*AXIS_W-1:0] div_next;

  always_comb begin
    trial     = {prod[2*AXIS_W-1:AXIS_W], prod[AXIS_W-1]};
    trial_sub = trial - {1'b0, span};
    mul_next  = {prod[2*AXIS_W-2:0], 1'b0} +
                (mul_sh[AXIS_W-1] ? {{AXIS_W{1'b0}}, diff} : '0);
    if (!trial_sub[AXIS_W]) begin
      div_next = {trial_sub[AXIS_W-1:0], prod[AXIS_W-2:0], 1'b1};
    end else begin
      div_next = {trial[AXIS_W-1:0], prod[AXIS_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      div_phase <= 1'b0;
      count     <= '0;
    end else if (start) begin
      prod <= '0;
      if (req.hi > req.lo) begin
        busy      <= 1'b1;
        div_phase <= 1'b0;
        count     <= '0;
        span      <= req.hi - req.lo;
        diff      <= req.value - req.lo;
        mul_sh    <= req.top;
      end
    end else if (busy) begin
      if (div_phase) begin
        prod <= div_next;
      end else begin
        prod   <= mul_next;
        mul_sh <= {mul_sh[AXIS_W-2:0], 1'b0};
      end
      if (count == LAST_STEP) begin
        count <= '0;
        if (div_phase) begin
          busy <= 1'b0;
        end else begin
          div_phase <= 1'b1;
        end
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  assign quo = prod[AXIS_W-1:0];

endmodule

FILE: sv/touch_report_filter.sv
// Touch report filter: one poll result in, one filtered report out.
// in_valid/in_ready/in_data carry one poll word (bus flag and four report
// bytes); out_valid/out_ready/out_data carry one report word per poll.
// cfg_valid/cfg_ready/cfg_index/cfg_data write the calibration, scaling
// and rotation registers; cfg_ready is always high, write only while idle.
// A poll that needs no rescale passes from S_IDLE through S_FINISH into
// the output register. With rescaling on, a fresh point goes through two
// bit-serial units (one per axis) running in parallel, shift-add multiply
// then restoring divide, in S_CALC before S_FINISH. One poll is in flight
// at a time: a new poll is not taken until the last one's report is written.
// The finished report sits in an output register; a stalled receiver
// holds it and the block waits to write the next one, but the following
// poll is accepted and worked on meanwhile.
// Reset (rst, synchronous) clears all filter state and restores register
// defaults: full 0..4095 calibration, no rescale, no rotation.
module touch_report_filter #(
  parameter int ERROR_LIMIT  = 5,
  parameter int STUCK_LIMIT  = 50,
  parameter int RANGE_MARGIN = 60
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  trf_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output trf_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data
);
  import trf_pkg::*;

  localparam logic [2:0]        ERR_LIM = 3'(ERROR_LIMIT);
  localparam logic [15:0]       STK_LIM = 16'(STUCK_LIMIT);
  localparam logic [AXIS_W:0]   MARGIN  = (AXIS_W+1)'(RANGE_MARGIN);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CALC   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state;

  // configuration
  logic [AXIS_W-1:0] x_cal_min, x_cal_max, y_cal_min, y_cal_max;
  logic [AXIS_W-1:0] x_scaled_max, y_scaled_max;
  logic              rescale_enable;
  logic [1:0]        rotation;

  // filter state
  logic [2:0]        error_run;
  logic [AXIS_W-1:0] prev_raw_x, prev_raw_y;
  logic [15:0]       repeat_run;
  logic              stuck_latched;
  logic              have_good_point;
  logic [AXIS_W-1:0] good_x, good_y;

  // pending result of the poll in flight
  logic              p_pressed, p_rst;
  logic [2:0]        p_status;
  logic [AXIS_W-1:0] p_x, p_y;

  logic              accept;
  logic [AXIS_W-1:0] rx, ry, cx, cy;
  logic [2:0]        err_inc;
  logic [15:0]       rr_inc;
  logic              same, out_of_range;
  logic              scale_start;
  scale_req_t        req_x, req_y;
  logic              busy_x, busy_y;
  logic [AXIS_W-1:0] quo_x, quo_y;
  logic [AXIS_W-1:0] sx, sy, xmax, ymax, ox, oy;
  logic              out_free;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    rx = {in_data.x_high_byte[3:0] & NIBBLE_MASK, in_data.x_low_byte};
    ry = {in_data.y_high_byte[3:0] & NIBBLE_MASK, in_data.y_low_byte};
    err_inc = error_run + 1'b1;
    rr_inc  = (repeat_run != REPEAT_MAX) ? repeat_run + 1'b1 : repeat_run;
    same    = (rx == prev_raw_x) && (ry == prev_raw_y);
    out_of_range = ({1'b0, rx} + MARGIN < {1'b0, x_cal_min}) ||
                   ({1'b0, rx} > {1'b0, x_cal_max} + MARGIN) ||
                   ({1'b0, ry} + MARGIN < {1'b0, y_cal_min}) ||
                   ({1'b0, ry} > {1'b0, y_cal_max} + MARGIN);
    // clamp to max first, then to min
    cx = (rx > x_cal_max) ? x_cal_max : rx;
    cx = (cx < x_cal_min) ? x_cal_min : cx;
    cy = (ry > y_cal_max) ? y_cal_max : ry;
    cy = (cy < y_cal_min) ? y_cal_min : cy;
    req_x = '{value: cx, lo: x_cal_min, hi: x_cal_max, top: x_scaled_max};
    req_y = '{value: cy, lo: y_cal_min, hi: y_cal_max, top: y_scaled_max};
  end

  assign scale_start = accept && in_data.bus_ok && (rx != '0 || ry != '0) &&
                       !(same && (stuck_latched || rr_inc == STK_LIM)) &&
                       !out_of_range && rescale_enable;

  trf_scale u_scale_x (
    .clk   (clk),
    .rst   (rst),
    .start (scale_start),
    .req   (req_x),
    .busy  (busy_x),
    .quo   (quo_x)
  );

  trf_scale u_scale_y (
    .clk   (clk),
    .rst   (rst),
    .start (scale_start),
    .req   (req_y),
    .busy  (busy_y),
    .quo   (quo_y)
  );

  always_comb begin
    sx   = rescale_enable ? quo_x : p_x;
    sy   = rescale_enable ? quo_y : p_y;
    xmax = rescale_enable ? x_scaled_max : x_cal_max;
    ymax = rescale_enable ? y_scaled_max : y_cal_max;
    case (rotation)
      ROT_90: begin
        ox = sy;
        oy = xmax - sx;
      end
      ROT_180: begin
        ox = xmax - sx;
        oy = ymax - sy;
      end
      ROT_270: begin
        ox = ymax - sy;
        oy = sx;
      end
      default: begin
        ox = sx;
        oy = sy;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      x_cal_min      <= '0;
      x_cal_max      <= '1;
      y_cal_min      <= '0;
      y_cal_max      <= '1;
      x_scaled_max   <= '1;
      y_scaled_max   <= '1;
      rescale_enable <= 1'b0;
      rotation       <= ROT_0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_CAL_MIN:    x_cal_min      <= cfg_data;
        REG_X_CAL_MAX:    x_cal_max      <= cfg_data;
        REG_Y_CAL_MIN:    y_cal_min      <= cfg_data;
        REG_Y_CAL_MAX:    y_cal_max      <= cfg_data;
        REG_X_SCALED_MAX: x_scaled_max   <= cfg_data;
        REG_Y_SCALED_MAX: y_scaled_max   <= cfg_data;
        REG_RESCALE:      rescale_enable <= cfg_data[0];
        REG_ROTATION:     rotation       <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // poll classification and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      error_run       <= '0;
      prev_raw_x      <= '0;
      prev_raw_y      <= '0;
      repeat_run      <= '0;
      stuck_latched   <= 1'b0;
      have_good_point <= 1'b0;
      good_x          <= '0;
      good_y          <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            p_pressed <= 1'b0;
            p_rst     <= 1'b0;
            p_x       <= cx;
            p_y       <= cy;
            state     <= S_FINISH;
            if (!in_data.bus_ok) begin
              p_status <= ST_BUS_ERR;
              if (err_inc >= ERR_LIM) begin
                error_run <= '0;
                p_rst     <= 1'b1;
              end else begin
                error_run <= err_inc;
              end
            end else begin
              error_run <= '0;
              if (rx == '0 && ry == '0) begin
                have_good_point <= 1'b0;
                repeat_run      <= '0;
                stuck_latched   <= 1'b0;
                p_status        <= ST_RELEASE;
              end else if (same && stuck_latched) begin
                have_good_point <= 1'b0;
                p_status        <= ST_STUCK;
              end else if (same && rr_inc == STK_LIM) begin
                repeat_run      <= rr_inc;
                have_good_point <= 1'b0;
                stuck_latched   <= 1'b1;
                p_rst           <= 1'b1;
                p_status        <= ST_STUCK_NEW;
              end else begin
                if (same) begin
                  repeat_run <= rr_inc;
                end else begin
                  prev_raw_x    <= rx;
                  prev_raw_y    <= ry;
                  repeat_run    <= '0;
                  stuck_latched <= 1'b0;
                end
                if (out_of_range) begin
                  // hold the last good point if there is one
                  p_pressed <= have_good_point;
                  p_status  <= have_good_point ? ST_HELD : ST_REJECTED;
                  p_x       <= have_good_point ? good_x : '0;
                  p_y       <= have_good_point ? good_y : '0;
                end else begin
                  p_pressed <= 1'b1;
                  p_status  <= ST_FRESH;
                  if (rescale_enable) begin
                    state <= S_CALC;
                  end
                end
              end
            end
          end
        end
        S_CALC: begin
          if (!busy_x && !busy_y) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid          <= 1'b1;
            out_data.pressed   <= p_pressed;
            out_data.reset_bus <= p_rst;
            out_data.status    <= p_status;
            if (p_status == ST_FRESH) begin
              out_data.point_x <= ox;
              out_data.point_y <= oy;
              good_x           <= ox;
              good_y           <= oy;
              have_good_point  <= 1'b1;
            end else if (p_pressed) begin
              out_data.point_x <= p_x;
              out_data.point_y <= p_y;
            end else begin
              out_data.point_x <= '0;
              out_data.point_y <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // the error run never rests at or above the bus reset threshold
  a_error_run_below_limit: assert property (@(posedge clk) disable iff (rst)
    error_run < ERR_LIM)
    else $error("error run reached the limit without a bus reset");

  // a bus reset goes out only with a bus error or a newly found stuck value
  a_reset_bus_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.reset_bus |->
      (out_data.status == ST_BUS_ERR || out_data.status == ST_STUCK_NEW))
    else $error("bus reset request with the wrong status");

  // the dividers are idle whenever a new poll can be taken
  a_scale_idle_on_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !busy_x && !busy_y)
    else $error("scale unit busy while ready for a new poll");

  // a fresh point always comes with pressed set
  a_fresh_is_pressed: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_FRESH |-> out_data.pressed)
    else $error("fresh point reported without pressed");
`endif

endmodule

FILE: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trf_pkg::*;

  localparam int ERR_LIMIT   = 5;
  localparam int STUCK_LIMIT = 50;
  localparam int MARGIN      = 60;
  localparam int DRAIN_PAD   = 40;
  localparam int LONG_HOLD   = 300;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [2:0]  cfg_index = REG_X_CAL_MIN;
  logic [11:0] cfg_data = '0;

  touch_report_filter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copy
  logic [11:0] cal_x_lo = 12'd0, cal_x_hi = 12'd4095;
  logic [11:0] cal_y_lo = 12'd0, cal_y_hi = 12'd4095;
  logic [11:0] top_x = 12'd4095, top_y = 12'd4095;
  logic        rescale_on = 1'b0;
  logic [1:0]  quarter_turns = ROT_0;

  // filter state copy
  logic [2:0]  err_run = '0;
  logic [11:0] last_x = '0, last_y = '0;
  logic [15:0] same_run = '0;
  logic        stuck_on = 1'b0, have_point = 1'b0;
  logic [11:0] held_x = '0, held_y = '0;

  in_word_t  poll_q[$];
  out_word_t reports_due[$];
  int        polls_queued = 0, polls_taken = 0;
  int        gap_pct = 0, stall_pct = 0;
  logic      rx_hold = 1'b0;
  logic      poll_taken = 1'b0;
  int        mism_count = 0, phases = 0;
  int        status_seen[8] = '{default: 0};
  int        bus_resets = 0;
  out_word_t want;

  function automatic logic [11:0] axis_scale(logic [11:0] v, logic [11:0] lo,
                                             logic [11:0] hi, logic [11:0] top);
    if (hi <= lo || v < lo) return 12'd0;
    return 12'(((int'(v) - int'(lo)) * int'(top)) / (int'(hi) - int'(lo)));
  endfunction

  function automatic out_word_t filter_poll(in_word_t w);
    out_word_t   r;
    logic [11:0] rx, ry, xm, ym, ox, oy;
    r = '0;
    if (!w.bus_ok) begin
      err_run = err_run + 3'd1;
      if (err_run >= ERR_LIMIT) begin
        err_run = '0;
        r.reset_bus = 1'b1;
      end
      r.status = ST_BUS_ERR;
      return r;
    end
    err_run = '0;
    rx = {w.x_high_byte[3:0], w.x_low_byte};
    ry = {w.y_high_byte[3:0], w.y_low_byte};
    if (rx == 0 && ry == 0) begin
      have_point = 1'b0;
      same_run = '0;
      stuck_on = 1'b0;
      r.status = ST_RELEASE;
      return r;
    end
    if (rx == last_x && ry == last_y) begin
      if (stuck_on) begin
        have_point = 1'b0;
        r.status = ST_STUCK;
        return r;
      end
      if (same_run != REPEAT_MAX) same_run = same_run + 16'd1;
      if (same_run == STUCK_LIMIT) begin
        err_run = '0;
        have_point = 1'b0;
        stuck_on = 1'b1;
        r.reset_bus = 1'b1;
        r.status = ST_STUCK_NEW;
        return r;
      end
    end else begin
      last_x = rx;
      last_y = ry;
      same_run = '0;
      stuck_on = 1'b0;
    end
    if (int'(rx) + MARGIN < int'(cal_x_lo) || int'(rx) > int'(cal_x_hi) + MARGIN ||
        int'(ry) + MARGIN < int'(cal_y_lo) || int'(ry) > int'(cal_y_hi) + MARGIN) begin
      if (have_point) begin
        r.pressed = 1'b1;
        r.point_x = held_x;
        r.point_y = held_y;
        r.status = ST_HELD;
      end else begin
        r.status = ST_REJECTED;
      end
      return r;
    end
    if (rx > cal_x_hi) rx = cal_x_hi;
    if (rx < cal_x_lo) rx = cal_x_lo;
    if (ry > cal_y_hi) ry = cal_y_hi;
    if (ry < cal_y_lo) ry = cal_y_lo;
    xm = cal_x_hi;
    ym = cal_y_hi;
    if (rescale_on) begin
      rx = axis_scale(rx, cal_x_lo, cal_x_hi, top_x);
      ry = axis_scale(ry, cal_y_lo, cal_y_hi, top_y);
      xm = top_x;
      ym = top_y;
    end
    // 12-bit subtraction wraps when the calibration is inverted
    case (quarter_turns)
      ROT_90: begin
        ox = ry;
        oy = xm - rx;
      end
      ROT_180: begin
        ox = xm - rx;
        oy = ym - ry;
      end
      ROT_270: begin
        ox = ym - ry;
        oy = rx;
      end
      default: begin
        ox = rx;
        oy = ry;
      end
    endcase
    held_x = ox;
    held_y = oy;
    have_point = 1'b1;
    r.pressed = 1'b1;
    r.point_x = ox;
    r.point_y = oy;
    r.status = ST_FRESH;
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int exp_val);
    $display("%0t ns: %s: got %0d, want %0d", $time, what, got, exp_val);
    mism_count++;
  endtask

  // driver: advance to the next poll once the current word is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || poll_taken) begin
      if (poll_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        in_data <= poll_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
  end

  // monitor: check the report side first, then predict for a taken poll
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (reports_due.size() == 0) begin
        flag_mismatch("report with nothing due, status", out_data.status, -1);
      end else begin
        want = reports_due.pop_front();
        status_seen[want.status]++;
        if (want.reset_bus) bus_resets++;
        if (out_data.pressed !== want.pressed)
          flag_mismatch("pressed", out_data.pressed, want.pressed);
        if (out_data.point_x !== want.point_x)
          flag_mismatch("point_x", out_data.point_x, want.point_x);
        if (out_data.point_y !== want.point_y)
          flag_mismatch("point_y", out_data.point_y, want.point_y);
        if (out_data.reset_bus !== want.reset_bus)
          flag_mismatch("reset_bus", out_data.reset_bus, want.reset_bus);
        if (out_data.status !== want.status)
          flag_mismatch("status", out_data.status, want.status);
      end
    end
    poll_taken = !rst && in_valid && in_ready;
    if (poll_taken) begin
      reports_due.push_back(filter_poll(in_data));
      polls_taken++;
    end
  end

  task automatic set_reg(logic [2:0] idx, logic [11:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_X_CAL_MIN:    cal_x_lo = val;
      REG_X_CAL_MAX:    cal_x_hi = val;
      REG_Y_CAL_MIN:    cal_y_lo = val;
      REG_Y_CAL_MAX:    cal_y_hi = val;
      REG_X_SCALED_MAX: top_x = val;
      REG_Y_SCALED_MAX: top_y = val;
      REG_RESCALE:      rescale_on = val[0];
      REG_ROTATION:     quarter_turns = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic setup_regs(logic [11:0] xlo, logic [11:0] xhi, logic [11:0] ylo,
                            logic [11:0] yhi, logic [11:0] xt, logic [11:0] yt,
                            logic en, logic [1:0] turns);
    set_reg(REG_X_CAL_MIN, xlo);
    set_reg(REG_X_CAL_MAX, xhi);
    set_reg(REG_Y_CAL_MIN, ylo);
    set_reg(REG_Y_CAL_MAX, yhi);
    set_reg(REG_X_SCALED_MAX, xt);
    set_reg(REG_Y_SCALED_MAX, yt);
    set_reg(REG_RESCALE, {11'd0, en});
    set_reg(REG_ROTATION, {10'd0, turns});
  endtask

  task automatic push_word(in_word_t w);
    poll_q.push_back(w);
    polls_queued++;
  endtask

  // unused high nibbles get random junk
  task automatic push_point(logic ok, logic [11:0] x, logic [11:0] y);
    in_word_t w;
    w = {1'($urandom), 32'($urandom)};
    w.bus_ok = ok;
    w.x_high_byte[3:0] = x[11:8];
    w.x_low_byte = x[7:0];
    w.y_high_byte[3:0] = y[11:8];
    w.y_low_byte = y[7:0];
    push_word(w);
  endtask

  // mostly near the calibrated window, sometimes anywhere
  function automatic logic [11:0] pick_axis(logic [11:0] lo, logic [11:0] hi);
    int a, b;
    a = (lo < hi ? int'(lo) : int'(hi)) - 70;
    b = (lo < hi ? int'(hi) : int'(lo)) + 70;
    if (a < 0) a = 0;
    if (b > 4095) b = 4095;
    if ($urandom_range(3) == 0) return 12'($urandom);
    return 12'($urandom_range(b, a));
  endfunction

  function automatic logic [11:0] nudge(logic [11:0] v);
    int t;
    t = int'(v) + int'($urandom_range(16)) - 8;
    if (t < 0) t = 0;
    if (t > 4095) t = 4095;
    return 12'(t);
  endfunction

  task automatic queue_bursts(int n);
    int          stop, kind, len;
    logic [11:0] x, y;
    stop = polls_queued + n;
    while (polls_queued < stop) begin
      kind = $urandom_range(39);
      x = pick_axis(cal_x_lo, cal_x_hi);
      y = pick_axis(cal_y_lo, cal_y_hi);
      if (x == 0 && y == 0) x = 12'd1;
      if (kind < 22) begin
        // drag, sometimes resting on one reading
        len = $urandom_range(10, 3);
        repeat (len) begin
          push_point(1'b1, x, y);
          if ($urandom_range(3) != 0) begin
            x = nudge(x);
            y = nudge(y);
          end
        end
      end else if (kind == 22) begin
        // hold one reading past the stuck limit
        repeat (STUCK_LIMIT + 1 + $urandom_range(4)) push_point(1'b1, x, y);
        if ($urandom_range(1) != 0) push_point(1'b1, 12'd0, 12'd0);
      end else if (kind == 23) begin
        // stop just short of the stuck limit, then move
        repeat (STUCK_LIMIT - $urandom_range(1)) push_point(1'b1, x, y);
        push_point(1'b1, x ^ 12'd1, y);
      end else if (kind < 31) begin
        repeat ($urandom_range(7, 1)) push_point(1'b0, 12'($urandom), 12'($urandom));
        push_point(1'b1, x, y);
      end else if (kind < 35) begin
        push_point(1'b1, 12'd0, 12'd0);
      end else begin
        push_word({1'($urandom), 32'($urandom)});
      end
    end
  endtask

  task automatic begin_phase(int gap, int stall);
    @(posedge clk);
    gap_pct = gap;
    stall_pct = stall;
    phases++;
  endtask

  task automatic wait_idle();
    while (polls_taken != polls_queued || reports_due.size() != 0) @(negedge clk);
    repeat (DRAIN_PAD) @(negedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // defaults: bus error runs, extremes, ignored high nibbles, release
    begin_phase(0, 0);
    repeat (5) push_point(1'b0, 12'($urandom), 12'($urandom));
    push_point(1'b0, 12'($urandom), 12'($urandom));
    push_word({1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    push_word({1'b1, 8'hF0, 8'h00, 8'hF0, 8'h00});
    push_point(1'b1, 12'd1, 12'd0);
    push_point(1'b1, 12'd0, 12'd1);
    push_point(1'b1, 12'd4095, 12'd0);
    push_point(1'b1, 12'd0, 12'd4095);
    push_word('0);
    push_word({1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    queue_bursts(88);
    wait_idle();

    // margin edges on both axes, rejected then held
    setup_regs(12'd200, 12'd3800, 12'd300, 12'd3900, 12'd4095, 12'd4095, 1'b0, ROT_90);
    begin_phase(55, 0);
    push_point(1'b1, 12'd0, 12'd0);
    push_point(1'b1, 12'd139, 12'd2000);
    push_point(1'b1, 12'd140, 12'd2000);
    push_point(1'b1, 12'd3861, 12'd2000);
    push_point(1'b1, 12'd3860, 12'd2000);
    push_point(1'b1, 12'd2000, 12'd239);
    push_point(1'b1, 12'd2000, 12'd240);
    push_point(1'b1, 12'd2000, 12'd3961);
    push_point(1'b1, 12'd2000, 12'd3960);
    queue_bursts(88);
    wait_idle();

    // long receiver hold-off while polls keep coming
    setup_regs(12'd200, 12'd3800, 12'd300, 12'd3900, 12'd1023, 12'd767, 1'b1, ROT_180);
    begin_phase(0, 55);
    fork
      begin
        rx_hold = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    queue_bursts(88);
    wait_idle();

    // inverted calibration, rescaled to nothing on X
    setup_regs(12'd2100, 12'd2000, 12'd3000, 12'd2990, 12'd0, 12'd4095, 1'b1, ROT_270);
    begin_phase(30, 30);
    queue_bursts(88);
    wait_idle();

    setup_regs(12'd2100, 12'd2000, 12'd3000, 12'd2990, 12'd4095, 12'd4095, 1'b0, ROT_180);
    begin_phase(0, 0);
    queue_bursts(88);
    wait_idle();

    setup_regs(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd4095, 1'b1, ROT_0);
    begin_phase(55, 0);
    queue_bursts(88);
    wait_idle();

    // zero X span, Y scaled down to one step
    setup_regs(12'd2048, 12'd2048, 12'd0, 12'd4095, 12'd4095, 12'd1, 1'b1, ROT_90);
    begin_phase(0, 55);
    queue_bursts(88);
    wait_idle();

    setup_regs(12'($urandom_range(1500)), 12'($urandom_range(4095, 2500)),
               12'($urandom_range(1500)), 12'($urandom_range(4095, 2500)),
               12'($urandom), 12'($urandom), 1'($urandom), 2'($urandom));
    begin_phase(30, 30);
    queue_bursts(88);
    wait_idle();

    // narrow window: most readings fall outside it
    setup_regs(12'd1000, 12'd1100, 12'd1000, 12'd1100, 12'd4095, 12'd4095, 1'b0,
               2'($urandom));
    begin_phase(0, 0);
    queue_bursts(88);
    wait_idle();

    $display("covered %0d polls in %0d register settings: %0d fresh, %0d held, %0d rejected",
             polls_taken, phases, status_seen[ST_FRESH], status_seen[ST_HELD],
             status_seen[ST_REJECTED]);
    $display("%0d bus errors, %0d bus resets, %0d releases, %0d stuck found, %0d discarded",
             status_seen[ST_BUS_ERR], bus_resets, status_seen[ST_RELEASE],
             status_seen[ST_STUCK_NEW], status_seen[ST_STUCK]);
    if (mism_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d reports still due", reports_due.size());
    $display("tb failed");
    $finish;
  end

endmodule

FILE: sim.f
sv/trf_pkg.sv
sv/trf_scale.sv
sv/touch_report_filter.sv
sim/tb.sv
